// ----- src/gaussian_pyramid_reduce_3x3_defines.svh -----
// ----------------------------------------------------------------------------
// gaussian pyramid reduce 3x3 - assertion macros
// shared concurrent assertion forms, clocked and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_PYRAMID_REDUCE_3X3_DEFINES_SVH
`define GAUSSIAN_PYRAMID_REDUCE_3X3_DEFINES_SVH

// same-cycle implication
`define GPR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/gpr_pkg.sv -----
// ----------------------------------------------------------------------------
// gpr_pkg
// constants and types shared by the pyramid reduce block
// ----------------------------------------------------------------------------
package gpr_pkg;

	localparam int MAX_WIDTH    = 2048;
	localparam int MAX_HEIGHT   = 2048;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	localparam int PIX_W     = 8;
	localparam int RGB_W     = 3 * PIX_W;
	localparam int VERT_W    = 10;
	localparam int SUM_W     = 12;
	localparam int COORD_W   = 10;
	localparam int ROW_W     = 11;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 4'd0,
		REG_IMAGE_HEIGHT = 4'd1
	} reg_idx_t;

	typedef struct packed {
		logic row_odd;
		logic row_one;
		logic row_last;
		logic col_odd;
		logic col_one;
		logic col_last;
	} pos_flags_t;

endpackage

// ----- src/gaussian_pyramid_reduce_3x3.sv -----
// ----------------------------------------------------------------------------
// gaussian_pyramid_reduce_3x3
// 3x3 binomial filter with 2:1 decimation in both directions, rgb stream
// ----------------------------------------------------------------------------
// usage:
//   pixels enter on s_axis in raster order, red in the low byte of tdata.
//   one output pixel leaves on m_axis for every even column and even row of
//   the input, in sixteenths, with its reduced column and row; tlast marks
//   the final output pixel of a frame.
//   image size is written on the cfg channel (index 0 width, 1 height); a
//   write restarts the frame and must come while no pixel is in flight.
//   throughput: one pixel per clock while m_axis is not stalled. the pixel
//   that completes a window passes the registered read of the two line
//   buffer rams and then the output register before its output appears.
//   the line buffers are read and written back once per pixel at the same
//   column address, which recurs only after a full row.
//   reset returns the size to 640x480 and the position to the frame start;
//   line buffer contents are not cleared.
//   when m_axis is stalled the whole pipe holds and s_axis_tready drops; the
//   input is taken again in the cycle the pending output transfers.
// ----------------------------------------------------------------------------
`include "gaussian_pyramid_reduce_3x3_defines.svh"

module gaussian_pyramid_reduce_3x3 #(
	parameter int MAX_WIDTH = gpr_pkg::MAX_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// in_red, in_green, in_blue
	input  logic [23:0]                   s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_red, out_green, out_blue, out_col, out_row
	output logic [55:0]                   m_axis_tdata,
	// frame_last
	output logic                          m_axis_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gpr_pkg::CFG_W-1:0]     cfg_data
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int SW = gpr_pkg::SUM_W;
	localparam int CW = gpr_pkg::COORD_W;

	logic                        en;
	logic                        accept;
	logic                        restart;
	logic [XW-1:0]               col;
	logic [gpr_pkg::ROW_W-1:0]   row;
	logic [XW-1:0]               width_last;
	logic [gpr_pkg::ROW_W-1:0]   height_last;
	gpr_pkg::pos_flags_t         flags;

	logic                        s1_valid;
	logic [gpr_pkg::RGB_W-1:0]   pix_s1;
	logic [XW-1:0]               col_s1;
	logic [gpr_pkg::ROW_W-1:0]   row_s1;
	gpr_pkg::pos_flags_t         flags_s1;

	logic [gpr_pkg::RGB_W-1:0]   rd_prev;
	logic [gpr_pkg::RGB_W-1:0]   rd_prev2;
	logic                        ram_we;
	logic                        hit;
	logic [3*SW-1:0]             sum;
	logic [XW-1:0]               col_half;

	logic                        out_valid_q;
	logic [3*SW-1:0]             out_sum_q;
	logic [CW-1:0]               out_col_q;
	logic [CW-1:0]               out_row_q;
	logic                        out_last_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && en;
	assign cfg_ready     = 1'b1;
	assign ram_we        = en && s1_valid;

	gpr_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.XW        (XW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.advance     (accept),
		.restart     (restart),
		.col         (col),
		.row         (row),
		.width_last  (width_last),
		.height_last (height_last),
		.flags       (flags)
	);

	// previous row, written with the current pixel
	gpr_ram #(
		.WIDTH (gpr_pkg::RGB_W),
		.DEPTH (MAX_WIDTH),
		.AW    (XW)
	) u_row_prev (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (pix_s1),
		.re    (en),
		.raddr (col),
		.rdata (rd_prev)
	);

	// row before that, written with what the previous row held
	gpr_ram #(
		.WIDTH (gpr_pkg::RGB_W),
		.DEPTH (MAX_WIDTH),
		.AW    (XW)
	) u_row_prev2 (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (rd_prev),
		.re    (en),
		.raddr (col),
		.rdata (rd_prev2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (en) begin
			s1_valid <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= s_axis_tdata;
			col_s1   <= col;
			row_s1   <= row;
			flags_s1 <= flags;
		end
	end

	gpr_filter u_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.update  (ram_we),
		.pix     (pix_s1),
		.prev    (rd_prev),
		.prev2   (rd_prev2),
		.flags   (flags_s1),
		.hit     (hit),
		.sum     (sum)
	);

	assign col_half = col_s1 >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= s1_valid && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_sum_q  <= sum;
			out_col_q  <= CW'(col_half);
			out_row_q  <= row_s1[CW:1];
			out_last_q <= flags_s1.col_last && flags_s1.row_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_row_q, out_col_q, out_sum_q};
	assign m_axis_tlast  = out_last_q;

	`GPR_ASSERT_SAME(a_no_rw_clash, clk, arst_n, ram_we && en, col_s1 != col || !accept,
		"line buffer read and write hit the same column")
	`GPR_ASSERT_SAME(a_col_range, clk, arst_n, 1'b1, col <= width_last && row <= height_last,
		"raster position beyond image size")
	`GPR_ASSERT_NEXT(a_restart_home, clk, arst_n, restart, col == '0 && row == '0,
		"frame restart did not return to origin")

endmodule

// ----- src/gpr_ram.sv -----
// ----------------------------------------------------------------------------
// gpr_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module gpr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/gpr_ctrl.sv -----
// ----------------------------------------------------------------------------
// gpr_ctrl
// size registers, frame restart and raster position of the next pixel
// ----------------------------------------------------------------------------
module gpr_ctrl #(
	parameter int MAX_WIDTH = gpr_pkg::MAX_WIDTH,
	parameter int XW        = $clog2(MAX_WIDTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [gpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gpr_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          advance,
	output logic                          restart,
	output logic [XW-1:0]                 col,
	output logic [gpr_pkg::ROW_W-1:0]     row,
	output logic [XW-1:0]                 width_last,
	output logic [gpr_pkg::ROW_W-1:0]     height_last,
	output gpr_pkg::pos_flags_t           flags
);

	localparam int RST_W = (gpr_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
		: gpr_pkg::RESET_WIDTH;

	logic [XW-1:0]             col_q;
	logic [gpr_pkg::ROW_W-1:0] row_q;
	logic [XW-1:0]             width_last_q;
	logic [gpr_pkg::ROW_W-1:0] height_last_q;
	logic                      wr_width;
	logic                      wr_height;
	logic [XW-1:0]             width_last_d;
	logic [gpr_pkg::ROW_W-1:0] height_last_d;

	always_comb begin
		wr_width  = 1'b0;
		wr_height = 1'b0;
		case (gpr_pkg::reg_idx_t'(cfg_index))
			gpr_pkg::REG_IMAGE_WIDTH:  wr_width  = cfg_valid;
			gpr_pkg::REG_IMAGE_HEIGHT: wr_height = cfg_valid;
			default: ;
		endcase
	end

	assign restart = wr_width | wr_height;

	// clamp to [2, max] and keep size minus one
	always_comb begin
		if (cfg_data < gpr_pkg::CFG_W'(2)) begin
			width_last_d = XW'(1);
		end else if (32'(cfg_data) > MAX_WIDTH) begin
			width_last_d = XW'(MAX_WIDTH - 1);
		end else begin
			width_last_d = XW'(cfg_data - gpr_pkg::CFG_W'(1));
		end
		if (cfg_data < gpr_pkg::CFG_W'(2)) begin
			height_last_d = gpr_pkg::ROW_W'(1);
		end else if (32'(cfg_data) > gpr_pkg::MAX_HEIGHT) begin
			height_last_d = gpr_pkg::ROW_W'(gpr_pkg::MAX_HEIGHT - 1);
		end else begin
			height_last_d = gpr_pkg::ROW_W'(cfg_data - gpr_pkg::CFG_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_last_q  <= XW'(RST_W - 1);
			height_last_q <= gpr_pkg::ROW_W'(gpr_pkg::RESET_HEIGHT - 1);
		end else begin
			if (wr_width) begin
				width_last_q <= width_last_d;
			end
			if (wr_height) begin
				height_last_q <= height_last_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_q == width_last_q) begin
				col_q <= '0;
				row_q <= (row_q == height_last_q) ? '0 : row_q + gpr_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	assign col         = col_q;
	assign row         = row_q;
	assign width_last  = width_last_q;
	assign height_last = height_last_q;

	always_comb begin
		flags.row_odd  = row_q[0];
		flags.row_one  = (row_q == gpr_pkg::ROW_W'(1));
		flags.row_last = (row_q == height_last_q);
		flags.col_odd  = col_q[0];
		flags.col_one  = (col_q == XW'(1));
		flags.col_last = (col_q == width_last_q);
	end

endmodule

// ----- src/gpr_filter.sv -----
// ----------------------------------------------------------------------------
// gpr_filter
// vertical column sums, two-column window and horizontal binomial sum
// ----------------------------------------------------------------------------
module gpr_filter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        restart,
	input  logic                        update,
	input  logic [gpr_pkg::RGB_W-1:0]   pix,
	input  logic [gpr_pkg::RGB_W-1:0]   prev,
	input  logic [gpr_pkg::RGB_W-1:0]   prev2,
	input  gpr_pkg::pos_flags_t         flags,
	output logic                        hit,
	output logic [3*gpr_pkg::SUM_W-1:0] sum
);

	localparam int PW = gpr_pkg::PIX_W;
	localparam int VW = gpr_pkg::VERT_W;
	localparam int SW = gpr_pkg::SUM_W;

	logic [3*VW-1:0] wc0_q;
	logic [3*VW-1:0] wc1_q;
	logic [3*VW-1:0] vert;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			logic [PW-1:0] cur;
			logic [PW-1:0] mid;
			logic [PW-1:0] top;
			logic [VW-1:0] w0;
			logic [VW-1:0] left;
			logic [VW-1:0] v;
			cur  = pix[ch*PW +: PW];
			mid  = prev[ch*PW +: PW];
			top  = flags.row_one ? mid : prev2[ch*PW +: PW];
			if (flags.row_odd) begin
				v = VW'(top) + VW'({mid, 1'b0}) + VW'(cur);
			end else begin
				v = VW'(mid) + VW'({cur, 1'b0}) + VW'(cur);
			end
			vert[ch*VW +: VW] = v;
			w0   = wc0_q[ch*VW +: VW];
			left = flags.col_one ? w0 : wc1_q[ch*VW +: VW];
			if (flags.col_odd) begin
				sum[ch*SW +: SW] = SW'(left) + SW'({w0, 1'b0}) + SW'(v);
			end else begin
				sum[ch*SW +: SW] = SW'(w0) + SW'({v, 1'b0}) + SW'(v);
			end
		end
	end

	assign hit = (flags.row_odd | flags.row_last) & (flags.col_odd | flags.col_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc0_q <= '0;
			wc1_q <= '0;
		end else if (restart) begin
			wc0_q <= '0;
			wc1_q <= '0;
		end else if (update) begin
			wc1_q <= wc0_q;
			wc0_q <= vert;
		end
	end

endmodule

// ----- dv/tb_gaussian_pyramid_reduce_3x3.sv -----
// ----------------------------------------------------------------------------
// tb_gaussian_pyramid_reduce_3x3
// self-checking bench for the 3x3 binomial reduce block. rgb pixels are
// streamed in with random gaps while the output side stalls at random. an
// in-bench model of the filter computes every reduced pixel, which is checked
// field by field in order. the run starts at the power-up size, then walks a
// short table of hand-written frames, then random sizes and frames, and ends
// on the largest and out-of-range sizes.
// ----------------------------------------------------------------------------
module tb_gaussian_pyramid_reduce_3x3;

	localparam int PIX_W        = gpr_pkg::PIX_W;
	localparam int VERT_W       = gpr_pkg::VERT_W;
	localparam int SUM_W        = gpr_pkg::SUM_W;
	localparam int COORD_W      = gpr_pkg::COORD_W;
	localparam int CFG_W        = gpr_pkg::CFG_W;
	localparam int CFG_IDX_W    = gpr_pkg::CFG_IDX_W;
	localparam int MAX_WIDTH    = gpr_pkg::MAX_WIDTH;
	localparam int MAX_HEIGHT   = gpr_pkg::MAX_HEIGHT;
	localparam int RESET_WIDTH  = gpr_pkg::RESET_WIDTH;
	localparam int RESET_HEIGHT = gpr_pkg::RESET_HEIGHT;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = gpr_pkg::REG_IMAGE_WIDTH;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = gpr_pkg::REG_IMAGE_HEIGHT;

	localparam int WATCHDOG_CYCLES = 1000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int POWERUP_PIXELS  = 24;
	localparam int RANDOM_PIXELS   = 400;

	localparam logic [CFG_IDX_W-1:0] IDX_FIRST_UNUSED = CFG_IDX_W'(REG_IMAGE_HEIGHT + 1);
	localparam logic [CFG_IDX_W-1:0] IDX_LAST_UNUSED  = '1;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} rgb_t;

	// same layout as {tlast, tdata} on the output side
	typedef struct packed {
		logic               last;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [SUM_W-1:0]   blue;
		logic [SUM_W-1:0]   green;
		logic [SUM_W-1:0]   red;
	} reduced_px_t;

	typedef enum logic {
		STEP_CFG,
		STEP_PIXEL
	} step_kind_t;

	typedef struct {
		step_kind_t             kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_W-1:0]       val;
		rgb_t                   px;
		bit                     typed;
		reduced_px_t            want;
	} script_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	// in_red, in_green, in_blue
	logic [23:0]          s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	// out_red, out_green, out_blue, out_col, out_row
	logic [55:0]          m_axis_tdata;
	// frame_last
	logic                 m_axis_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// filter model state
	logic [PIX_W-1:0]  line_prev  [MAX_WIDTH][3];
	logic [PIX_W-1:0]  line_prev2 [MAX_WIDTH][3];
	logic [VERT_W-1:0] col_sum_prev  [3];
	logic [VERT_W-1:0] col_sum_prev2 [3];
	int unsigned       col_pos;
	int unsigned       row_pos;
	logic [CFG_W-1:0]  width_reg;
	logic [CFG_W-1:0]  height_reg;

	reduced_px_t pending_px [$];
	script_row_t script [$];
	string       field_name [6] = '{"out_red", "out_green", "out_blue",
		"out_col", "out_row", "frame_last"};
	int          mismatches  = 0;
	int          idle_cycles = 0;
	bit          quiet       = 1'b0;

	gaussian_pyramid_reduce_3x3 dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned hi);
		if (v < 2) return 2;
		if (v > hi) return hi;
		return 32'(v);
	endfunction

	function automatic void restart_frame();
		col_pos = 0;
		row_pos = 0;
		for (int ch = 0; ch < 3; ch++) begin
			col_sum_prev[ch]  = '0;
			col_sum_prev2[ch] = '0;
		end
	endfunction

	// one input pixel through the filter, at most one reduced pixel out
	function automatic void reduce_step(input rgb_t px, output bit hit,
			output reduced_px_t res);
		int unsigned       w_eff;
		int unsigned       h_eff;
		logic [PIX_W-1:0]  cur [3];
		logic [VERT_W-1:0] vert [3];
		logic [SUM_W-1:0]  acc [3];
		bit                row_odd;
		bit                col_odd;
		bit                row_hit;
		bit                col_hit;
		int unsigned       r;
		int unsigned       c;

		w_eff   = clamp_size(width_reg, MAX_WIDTH);
		h_eff   = clamp_size(height_reg, MAX_HEIGHT);
		cur[0]  = px.red;
		cur[1]  = px.green;
		cur[2]  = px.blue;
		row_odd = (row_pos % 2) == 1;
		col_odd = (col_pos % 2) == 1;

		for (int ch = 0; ch < 3; ch++) begin
			if (row_odd)
				vert[ch] = VERT_W'((row_pos == 1 ? line_prev[col_pos][ch]
					: line_prev2[col_pos][ch]) + 2 * line_prev[col_pos][ch] + cur[ch]);
			else
				vert[ch] = VERT_W'(line_prev[col_pos][ch] + 3 * cur[ch]);
		end

		row_hit = row_odd || (row_pos == h_eff - 1);
		col_hit = col_odd || (col_pos == w_eff - 1);
		r       = row_odd ? row_pos - 1 : row_pos;
		c       = col_odd ? col_pos - 1 : col_pos;
		hit     = row_hit && col_hit;
		res     = '0;

		if (hit) begin
			for (int ch = 0; ch < 3; ch++) begin
				if (col_odd)
					acc[ch] = SUM_W'((col_pos == 1 ? col_sum_prev[ch] : col_sum_prev2[ch])
						+ 2 * col_sum_prev[ch] + vert[ch]);
				else
					acc[ch] = SUM_W'(col_sum_prev[ch] + 3 * vert[ch]);
			end
			res.red   = acc[0];
			res.green = acc[1];
			res.blue  = acc[2];
			res.col   = COORD_W'(c >> 1);
			res.row   = COORD_W'(r >> 1);
			res.last  = (col_pos == w_eff - 1) && (row_pos == h_eff - 1);
		end

		for (int ch = 0; ch < 3; ch++) begin
			line_prev2[col_pos][ch] = line_prev[col_pos][ch];
			line_prev[col_pos][ch]  = cur[ch];
			col_sum_prev2[ch]       = col_sum_prev[ch];
			col_sum_prev[ch]        = vert[ch];
		end

		col_pos++;
		if (col_pos >= w_eff) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h_eff)
				row_pos = 0;
		end
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (quiet) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65) return 0;
		if (roll < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic rgb_t random_pixel();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return '0;
		if (roll == 1) return '1;
		return rgb_t'(24'($urandom));
	endfunction

	function automatic logic [CFG_W-1:0] pick_size();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return CFG_W'($urandom_range(2, 9));
		if (roll < 95) return CFG_W'($urandom_range(2, 24));
		return CFG_W'($urandom_range(0, 1));
	endfunction

	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		script_row_t row;
		row = '{kind: STEP_CFG, idx: idx, val: val, px: '0, typed: 1'b0, want: '0};
		script.push_back(row);
	endfunction

	function automatic void add_px(rgb_t px, bit typed, reduced_px_t want);
		script_row_t row;
		row = '{kind: STEP_PIXEL, idx: '0, val: '0, px: px, typed: typed, want: want};
		script.push_back(row);
	endfunction

	// drop valid, let every expected pixel drain, then let the pipe go quiet
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_px.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_IMAGE_WIDTH) begin
			width_reg = val;
			restart_frame();
		end else if (idx == REG_IMAGE_HEIGHT) begin
			height_reg = val;
			restart_frame();
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_pixel(input rgb_t px, input bit typed, input reduced_px_t want);
		int unsigned gap;
		bit          hit;
		reduced_px_t res;

		gap = pick_gap();
		if (gap != 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		reduce_step(px, hit, res);
		if (hit)
			pending_px.push_back(typed ? want : res);
	endtask

	// output side stalls
	initial begin
		int unsigned stall;
		stall = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : check_output
		reduced_px_t      got;
		reduced_px_t      want;
		logic [SUM_W-1:0] want_f [6];
		logic [SUM_W-1:0] got_f  [6];

		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tlast, m_axis_tdata};
			if (pending_px.size() == 0) begin
				$display("%0t: output transfer expected none, got %h", $time, got);
				mismatches++;
			end else begin
				want   = pending_px.pop_front();
				want_f = '{want.red, want.green, want.blue, want.col, want.row, want.last};
				got_f  = '{got.red, got.green, got.blue, got.col, got.row, got.last};
				for (int i = 0; i < 6; i++) begin
					if (got_f[i] !== want_f[i]) begin
						$display("%0t: %s expected %0d, got %0d", $time, field_name[i],
							want_f[i], got_f[i]);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int unsigned n;
		int unsigned count;
		int unsigned frame_px;
		int unsigned big_w [3];
		int unsigned big_h [3];
		int unsigned big_n [3];

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;

		for (int x = 0; x < MAX_WIDTH; x++) begin
			for (int ch = 0; ch < 3; ch++) begin
				line_prev[x][ch]  = '0;
				line_prev2[x][ch] = '0;
			end
		end
		width_reg  = CFG_W'(RESET_WIDTH);
		height_reg = CFG_W'(RESET_HEIGHT);
		restart_frame();

		// small frames with results that follow from flat images
		add_cfg(REG_IMAGE_WIDTH, CFG_W'(2));
		add_cfg(REG_IMAGE_HEIGHT, CFG_W'(2));
		for (n = 0; n < 4; n++)
			add_px('1, n == 3, '{last: 1'b1, row: 0, col: 0, blue: 4080, green: 4080,
				red: 4080});
		for (n = 0; n < 4; n++)
			add_px('0, n == 3, '{last: 1'b1, default: '0});
		// sizes below the minimum clamp to 2x2
		add_cfg(REG_IMAGE_WIDTH, CFG_W'(0));
		add_cfg(REG_IMAGE_HEIGHT, CFG_W'(1));
		for (n = 0; n < 4; n++)
			add_px('{blue: 128, green: 0, red: 255}, n == 3,
				'{last: 1'b1, row: 0, col: 0, blue: 2048, green: 0, red: 4080});
		// unused index leaves the size and the frame position alone
		add_cfg(IDX_LAST_UNUSED, CFG_W'(3));
		for (n = 0; n < 4; n++)
			add_px('{blue: 3, green: 2, red: 1}, n == 3,
				'{last: 1'b1, row: 0, col: 0, blue: 48, green: 32, red: 16});
		// odd sizes, far edge clamped
		add_cfg(REG_IMAGE_WIDTH, CFG_W'(3));
		add_cfg(REG_IMAGE_HEIGHT, CFG_W'(3));
		for (n = 0; n < 9; n++)
			add_px('{blue: 8'(n * n * 3), green: 8'(255 - n * 31), red: 8'(n * 29)},
				1'b0, '0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// power-up size: part of the first row, nothing may come out
		for (n = 0; n < POWERUP_PIXELS; n++)
			push_pixel(random_pixel(), 1'b0, '0);

		foreach (script[i]) begin
			if (script[i].kind == STEP_CFG) begin
				settle();
				write_size_reg(script[i].idx, script[i].val);
			end else begin
				push_pixel(script[i].px, script[i].typed, script[i].want);
			end
		end

		n = 0;
		while (n < RANDOM_PIXELS) begin
			settle();
			quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) == 0)
				write_size_reg(CFG_IDX_W'($urandom_range(IDX_LAST_UNUSED, IDX_FIRST_UNUSED)),
					CFG_W'($urandom));
			if ($urandom_range(0, 1) == 0)
				write_size_reg(REG_IMAGE_WIDTH, pick_size());
			if ($urandom_range(0, 1) == 0)
				write_size_reg(REG_IMAGE_HEIGHT, pick_size());
			frame_px = clamp_size(width_reg, MAX_WIDTH) * clamp_size(height_reg, MAX_HEIGHT);
			if ($urandom_range(0, 4) == 0)
				count = $urandom_range(1, frame_px);
			else
				count = $urandom_range(1, 2) * frame_px + $urandom_range(0, 3);
			if (count > RANDOM_PIXELS - n)
				count = RANDOM_PIXELS - n;
			for (int k = 0; k < count; k++) begin
				if ($urandom_range(0, 59) == 0)
					settle();
				push_pixel(random_pixel(), 1'b0, '0);
			end
			n += count;
		end

		// widest and tallest frames, including sizes above the maximum
		quiet = 1'b0;
		big_w = '{4095, 2, MAX_WIDTH};
		big_h = '{3, 4095, MAX_HEIGHT};
		big_n = '{40, 48, 16};
		for (int b = 0; b < 3; b++) begin
			settle();
			write_size_reg(REG_IMAGE_WIDTH, CFG_W'(big_w[b]));
			write_size_reg(REG_IMAGE_HEIGHT, CFG_W'(big_h[b]));
			for (int k = 0; k < big_n[b]; k++)
				push_pixel(random_pixel(), 1'b0, '0);
		end

		settle();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/gpr_pkg.sv
src/gpr_ram.sv
src/gpr_ctrl.sv
src/gpr_filter.sv
src/gaussian_pyramid_reduce_3x3.sv
dv/tb_gaussian_pyramid_reduce_3x3.sv
